[sv/fmd_pkg.sv]
package fmd_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int GUARD_SHIFT = 14;
    localparam int QWIDTH      = 32 + FRAC_BITS;
    localparam int QDEPTH      = 4;

    typedef enum logic {
        MODE_MUL = 1'b0,
        MODE_DIV = 1'b1
    } mode_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] lhs;
        logic [31:0] rhs;
    } in_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic        saturated;
    } out_item_t;

    // Classified operation passed from the front end to the back end.
    typedef struct packed {
        logic        is_div;
        logic        sat;
        logic        neg;
        logic [31:0] op_a;
        logic [31:0] op_b;
        logic [31:0] sat_value;
    } op_t;

endpackage

[sv/fmd_front.sv]
module fmd_front import fmd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     op_valid,
    input  logic     op_ready,
    output op_t      op_data
);

    logic        valid_reg;
    op_t         op_reg;
    op_t         op_next;
    logic [31:0] mag_a;
    logic [31:0] mag_b;

    assign mag_a = s_data.lhs[31] ? (32'd0 - s_data.lhs) : s_data.lhs;
    assign mag_b = s_data.rhs[31] ? (32'd0 - s_data.rhs) : s_data.rhs;

    always_comb begin
        op_next.is_div = (s_data.mode == MODE_DIV);
        op_next.neg    = s_data.lhs[31] ^ s_data.rhs[31];
        op_next.sat    = op_next.is_div && ((mag_a >> GUARD_SHIFT) >= mag_b);
        op_next.sat_value = op_next.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if (op_next.is_div) begin
            op_next.op_a = mag_a;
            op_next.op_b = mag_b;
        end else begin
            op_next.op_a = s_data.lhs;
            op_next.op_b = s_data.rhs;
        end
    end

    assign s_ready  = !valid_reg || op_ready;
    assign op_valid = valid_reg;
    assign op_data  = op_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            op_reg <= op_next;
        end
    end

endmodule

[sv/fmd_queue.sv]
module fmd_queue import fmd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  op_t  wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output op_t  rd_data
);

    localparam int AW = $clog2(QDEPTH);

    op_t           mem_reg [QDEPTH];
    logic [AW-1:0] wptr_reg;
    logic [AW-1:0] rptr_reg;
    logic [AW:0]   count_reg;
    logic          do_wr;
    logic          do_rd;

    assign wr_ready = (count_reg != (AW+1)'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_wr) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_rd) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (do_wr) begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

[sv/fmd_back.sv]
module fmd_back import fmd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      op_valid,
    output logic      op_ready,
    input  op_t       op_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int NSTG = QWIDTH;

    // Stage 0 holds the multiply product; stages 1..NSTG run one restoring
    // divide step each.
    logic                    vld_reg  [NSTG+1];
    op_t                     op_reg   [NSTG+1];
    logic [QWIDTH-1:0]       quo_reg  [NSTG+1];
    logic [32:0]             rem_reg  [NSTG+1];
    logic signed [63:0]      prod_reg;
    logic                    out_valid_reg;
    out_item_t               out_reg;
    out_item_t               out_next;
    logic                    adv;
    logic [QWIDTH-1:0]       dividend;
    logic [63:0]             prod_shift;
    logic [QWIDTH-1:0]       qneg;

    assign adv      = !out_valid_reg || m_ready;
    assign op_ready = adv;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign dividend = {op_data.op_a, FRAC_BITS'(0)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= NSTG; i++) begin
                vld_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= op_valid;
            for (int i = 1; i <= NSTG; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_valid_reg <= vld_reg[NSTG];
        end
        if (adv) begin
            op_reg[0]  <= op_data;
            quo_reg[0] <= dividend;
            rem_reg[0] <= '0;
            prod_reg   <= $signed(op_data.op_a) * $signed(op_data.op_b);
            for (int i = 1; i <= NSTG; i++) begin
                logic [32:0] trial;
                trial = {rem_reg[i-1][31:0], quo_reg[i-1][QWIDTH-1]};
                op_reg[i] <= op_reg[i-1];
                if (trial >= {1'b0, op_reg[i-1].op_b}) begin
                    rem_reg[i] <= trial - {1'b0, op_reg[i-1].op_b};
                    quo_reg[i] <= {quo_reg[i-1][QWIDTH-2:0], 1'b1};
                end else begin
                    rem_reg[i] <= trial;
                    quo_reg[i] <= {quo_reg[i-1][QWIDTH-2:0], 1'b0};
                end
            end
            out_reg <= out_next;
        end
    end

    // The product travels alongside the divide stages in a delay line.
    logic [31:0] mul_reg [NSTG];

    always_ff @(posedge aclk) begin
        if (adv) begin
            mul_reg[0] <= prod_shift[31:0];
            for (int i = 1; i < NSTG; i++) begin
                mul_reg[i] <= mul_reg[i-1];
            end
        end
    end

    assign prod_shift = 64'(prod_reg >>> FRAC_BITS);
    assign qneg       = QWIDTH'(0) - quo_reg[NSTG];

    always_comb begin
        out_next.saturated = 1'b0;
        if (!op_reg[NSTG].is_div) begin
            out_next.value = mul_reg[NSTG-1];
        end else if (op_reg[NSTG].sat) begin
            out_next.value     = op_reg[NSTG].sat_value;
            out_next.saturated = 1'b1;
        end else if (op_reg[NSTG].neg) begin
            out_next.value = qneg[31:0];
        end else begin
            out_next.value = quo_reg[NSTG][31:0];
        end
    end

endmodule

[sv/fixed_16_16_mul_div_unit_top.sv]
// Channel   Ports                              Direction
// input     s_valid, s_ready, s_data           in
// result    m_valid, m_ready, m_data           out
// One transaction is accepted per cycle when the result side keeps up.
// Path: classify stage, queue, product stage, one restoring divide step per
// stage for each of the 48 quotient bits, then the output register.
// The whole back end stalls together while a result waits with m_ready low;
// the queue of four lets the front end keep accepting until it fills.
// Reset is synchronous and active low and empties every stage.
module fixed_16_16_mul_div_unit_top import fmd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic f_valid;
    logic f_ready;
    op_t  f_data;
    logic q_valid;
    logic q_ready;
    op_t  q_data;

    fmd_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .op_valid(f_valid), .op_ready(f_ready), .op_data(f_data)
    );

    fmd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
    );

    fmd_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .op_valid(q_valid), .op_ready(q_ready), .op_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    a_sat_only_div: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
            (m_data.value == 32'h8000_0000 || m_data.value == 32'h7FFF_FFFF))
        else $error("saturated result is not a clamp value");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

[dv/tb_fixed_16_16_mul_div_unit_top.sv]
`timescale 1ns / 1ps

module tb_fixed_16_16_mul_div_unit_top;
    import fmd_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    fixed_16_16_mul_div_unit_top DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    typedef struct {
        logic        mode;
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic        known;
        logic [31:0] value;
        logic        saturated;
    } vector_t;

    out_item_t pending_results[$];
    int        fail_count = 0;
    int        result_count = 0;
    int        sat_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    function automatic logic [31:0] abs32(logic [31:0] x);
        return x[31] ? (32'd0 - x) : x;
    endfunction

    function automatic out_item_t fixed_result(logic mode, logic [31:0] a, logic [31:0] b);
        out_item_t   r;
        logic [63:0] prod;
        logic [63:0] quot;
        logic [31:0] ma;
        logic [31:0] mb;
        logic        neg;
        r = '0;
        if (mode == MODE_MUL) begin
            prod = $signed(a) * $signed(b);
            r.value = prod[FRAC_BITS +: 32];
        end else begin
            ma = abs32(a);
            mb = abs32(b);
            neg = a[31] ^ b[31];
            if ((ma >> GUARD_SHIFT) >= mb) begin
                r.saturated = 1'b1;
                r.value = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                quot = ({32'd0, ma} << FRAC_BITS) / {32'd0, mb};
                if (neg) begin
                    quot = 64'd0 - quot;
                end
                r.value = quot[31:0];
            end
        end
        return r;
    endfunction

    task automatic send_operands(logic mode, logic [31:0] a, logic [31:0] b,
                                 logic known, out_item_t given);
        out_item_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        r = known ? given : fixed_result(mode, a, b);
        s_valid <= 1'b1;
        s_data <= '{mode: mode, lhs: a, rhs: b};
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        pending_results.push_back(r);
    endtask

    task automatic send_random(int n);
        logic        mode;
        logic [31:0] a;
        logic [31:0] b;
        for (int i = 0; i < n; i++) begin
            mode = 1'($urandom_range(1));
            a = $urandom;
            b = $urandom;
            case ($urandom_range(5))
                0: b = $urandom_range(3) - 1;
                1: b = $signed(b) >>> $urandom_range(31);
                2: a = $signed(a) >>> $urandom_range(31);
                3: a = {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
                default: ;
            endcase
            send_operands(mode, a, b, 1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                result_count++;
                if (m_data.saturated) begin
                    sat_count++;
                end
                if (pending_results.size() == 0) begin
                    $error("unexpected result value=%h saturated=%b", m_data.value,
                           m_data.saturated);
                    fail_count++;
                end else begin
                    if (m_data.value !== pending_results[0].value) begin
                        $error("value expected %h actual %h", pending_results[0].value,
                               m_data.value);
                        fail_count++;
                    end
                    if (m_data.saturated !== pending_results[0].saturated) begin
                        $error("saturated expected %b actual %b",
                               pending_results[0].saturated, m_data.saturated);
                        fail_count++;
                    end
                    void'(pending_results.pop_front());
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    vector_t directed[] = '{
        '{MODE_MUL, 32'h0001_0000, 32'h0001_0000, 1'b1, 32'h0001_0000, 1'b0},
        '{MODE_MUL, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
        '{MODE_MUL, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{MODE_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{MODE_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{MODE_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{MODE_MUL, 32'hFFFE_0000, 32'h0003_8000, 1'b0, 32'h0, 1'b0},
        '{MODE_DIV, 32'h0001_0000, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1},
        '{MODE_DIV, 32'hFFFF_0000, 32'h0000_0000, 1'b1, 32'h8000_0000, 1'b1},
        '{MODE_DIV, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1},
        '{MODE_DIV, 32'h8000_0000, 32'h0000_0001, 1'b1, 32'h8000_0000, 1'b1},
        '{MODE_DIV, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0001_0000, 1'b0},
        '{MODE_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{MODE_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1},
        '{MODE_DIV, 32'h0002_0000, 32'h0000_0008, 1'b1, 32'h7FFF_FFFF, 1'b1},
        '{MODE_DIV, 32'h0002_0000, 32'h0000_0009, 1'b0, 32'h0, 1'b0},
        '{MODE_DIV, 32'h0001_0000, 32'h0002_0000, 1'b1, 32'h0000_8000, 1'b0},
        '{MODE_DIV, 32'hFFFF_0000, 32'h0003_0000, 1'b0, 32'h0, 1'b0},
        '{MODE_DIV, 32'h0000_0001, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
        '{MODE_DIV, 32'h7FFF_FFFF, 32'h0002_0000, 1'b1, 32'h3FFF_FFFF, 1'b0},
        '{MODE_DIV, 32'h7FFF_FFFF, 32'h0002_0001, 1'b0, 32'h0, 1'b0}
    };

    initial begin
        out_item_t given;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i]) begin
            given = '{value: directed[i].value, saturated: directed[i].saturated};
            send_operands(directed[i].mode, directed[i].lhs, directed[i].rhs,
                          directed[i].known, given);
        end
        send_idle_pct = 32;
        recv_idle_pct = 64;
        send_random(180);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        send_idle_pct = 64;
        recv_idle_pct = 32;
        send_random(180);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(180);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (60) @(posedge aclk);
        $display("Ran %0d directed and 540 random transactions; %0d results checked,",
                 directed.size(), result_count);
        $display("%0d of them clamped by the divide guard.", sat_count);
        if (fail_count == 0) begin
            $display("fixed_16_16_mul_div_unit_top test passed");
        end else begin
            $display("fixed_16_16_mul_div_unit_top test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("fixed_16_16_mul_div_unit_top test failed");
        $finish;
    end

endmodule
